### rtl/core/owvm_pkg.sv
// ----------------------------------------------------------------------------
// owvm_pkg
// Shared types, codes and constants of the omni wheel velocity mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package owvm_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ROT_W        = 33;   // CORDIC x and y, signed
   localparam int ANG_W        = 32;   // CORDIC residual angle, signed
   localparam int GOAL_W       = 24;
   localparam logic signed [ROT_W-1:0] CORDIC_START = 33'sd652032874;
   localparam logic signed [ROT_W-1:0] UNIT_COS     = 33'sd1073741824;
   localparam logic signed [GOAL_W-1:0] GOAL_MAX    = 24'sh7FFFFF;
   localparam logic signed [GOAL_W-1:0] GOAL_MIN    = 24'sh800000;

   localparam logic [1:0] CMD_CHASSIS  = 2'd0;
   localparam logic [1:0] CMD_TURRET   = 2'd1;
   localparam logic [1:0] CMD_ABSOLUTE = 2'd2;
   localparam logic [1:0] CMD_TICK     = 2'd3;

   localparam logic [2:0] REG_CHASSIS_RADIUS = 3'd0;
   localparam logic [2:0] REG_WHEEL_SCALE    = 3'd1;
   localparam logic [2:0] REG_NORTH_OFFSET   = 3'd2;
   localparam logic [2:0] REG_YAW_OFFSET     = 3'd3;
   localparam logic [2:0] REG_TIMEOUT_TICKS  = 3'd4;
   localparam logic [2:0] REG_REVERSE        = 3'd5;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ROTATE,
      S_PRODUCT,
      S_SUM,
      S_ROUND,
      S_SCALE,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic                    valid;
      logic signed [ROT_W-1:0] x;
      logic signed [ROT_W-1:0] y;
      logic signed [ANG_W-1:0] z;
   } cordic_type;

   function automatic logic signed [ANG_W-1:0] atan_turn(input int step);
      logic signed [ANG_W-1:0] a;
      case (step)
         0:       a = 32'sd536870912;
         1:       a = 32'sd316933406;
         2:       a = 32'sd167458907;
         3:       a = 32'sd85004756;
         4:       a = 32'sd42667331;
         5:       a = 32'sd21354465;
         6:       a = 32'sd10679838;
         7:       a = 32'sd5340245;
         8:       a = 32'sd2670163;
         9:       a = 32'sd1335087;
         10:      a = 32'sd667544;
         11:      a = 32'sd333772;
         12:      a = 32'sd166886;
         13:      a = 32'sd83443;
         14:      a = 32'sd41722;
         15:      a = 32'sd20861;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

### rtl/core/owvm_chan_if.sv
// ----------------------------------------------------------------------------
// owvm channel interfaces
// Valid/ready channels for motion commands and wheel goal results.
// ----------------------------------------------------------------------------
`default_nettype none

interface owvm_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         command;
   logic signed [15:0] velocity_x;
   logic signed [15:0] velocity_y;
   logic signed [15:0] turn_rate;
   logic [15:0]        gimbal_angle;
   logic [15:0]        motor_angle;

   modport source (output valid, command, velocity_x, velocity_y, turn_rate,
                   gimbal_angle, motor_angle, input ready);
   modport sink   (input valid, command, velocity_x, velocity_y, turn_rate,
                   gimbal_angle, motor_angle, output ready);
endinterface

interface owvm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] front_speed;
   logic signed [23:0] left_speed;
   logic signed [23:0] back_speed;
   logic signed [23:0] right_speed;
   logic               stale;

   modport source (output valid, front_speed, left_speed, back_speed, right_speed,
                   stale, input ready);
   modport sink   (input valid, front_speed, left_speed, back_speed, right_speed,
                   stale, output ready);
endinterface

`default_nettype wire

### rtl/core/owvm_cordic_cell.sv
// ----------------------------------------------------------------------------
// owvm_cordic_cell
// One CORDIC rotation step; hands its vector to the next cell every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module owvm_cordic_cell #(
   parameter int STEP = 0
) (
   input  wire                  clock,
   input  wire                  reset,
   input  owvm_pkg::cordic_type cell_in,
   output owvm_pkg::cordic_type cell_out
);

   logic                              valid_ff;
   logic signed [owvm_pkg::ROT_W-1:0] x_ff, x_in;
   logic signed [owvm_pkg::ROT_W-1:0] y_ff, y_in;
   logic signed [owvm_pkg::ANG_W-1:0] z_ff, z_in;
   logic signed [owvm_pkg::ROT_W-1:0] dx, dy;

   always_comb begin
      dx = cell_in.y >>> STEP;
      dy = cell_in.x >>> STEP;
      if (!cell_in.z[owvm_pkg::ANG_W-1]) begin
         x_in = cell_in.x - dx;
         y_in = cell_in.y + dy;
         z_in = cell_in.z - owvm_pkg::atan_turn(STEP);
      end else begin
         x_in = cell_in.x + dx;
         y_in = cell_in.y - dy;
         z_in = cell_in.z + owvm_pkg::atan_turn(STEP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cell_in.valid;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign cell_out = '{valid: valid_ff, x: x_ff, y: y_ff, z: z_ff};

endmodule

`default_nettype wire

### rtl/core/omni_wheel_velocity_mixer.sv
// ----------------------------------------------------------------------------
// omni_wheel_velocity_mixer
// Inverse kinematics for a four-wheel omni chassis with staleness timeout.
// ----------------------------------------------------------------------------
//  channel  direction  handshake        content
//  req      in         valid/ready      command, velocities, angles
//  rsp      out        valid/ready      four wheel goals, stale flag
//  csr      in         APB write/read   six setup registers
//
//  A motion command passes from acceptance through a start register and the
//  16 cells of the CORDIC cell row, then fold, product, sum, round and scale
//  stages. A timer tick goes from the idle step straight to the final step.
//  One transaction is in flight at a time; input is ready again in the cycle
//  after the result is loaded. Reset clears the goals and marks the block stale.
//  A full result register holds the block in its last step until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module omni_wheel_velocity_mixer #(
   parameter int ANGLE_BITS = 16
) (
   input  wire          clock,
   input  wire          reset,
   owvm_req_if.sink     req,
   owvm_rsp_if.source   rsp,
   input  wire          csr_psel,
   input  wire          csr_penable,
   input  wire          csr_pwrite,
   input  wire  [4:0]   csr_paddr,
   input  wire  [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int ANGLE_SHIFT = 32 - ANGLE_BITS;
   localparam int NSTEP = owvm_pkg::CORDIC_STEPS;
   localparam int RW = owvm_pkg::ROT_W;
   localparam int GW = owvm_pkg::GOAL_W;

   // configuration
   logic [15:0] radius_ff, scale_ff, north_ff, yaw_ff, timeout_ff;
   logic        reverse_ff;
   logic        csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff  <= 16'd19661;
         scale_ff   <= 16'd4096;
         north_ff   <= 16'd0;
         yaw_ff     <= 16'd0;
         timeout_ff <= 16'd100;
         reverse_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_paddr[4:2])
            owvm_pkg::REG_CHASSIS_RADIUS: radius_ff  <= csr_pwdata[15:0];
            owvm_pkg::REG_WHEEL_SCALE:    scale_ff   <= csr_pwdata[15:0];
            owvm_pkg::REG_NORTH_OFFSET:   north_ff   <= csr_pwdata[15:0];
            owvm_pkg::REG_YAW_OFFSET:     yaw_ff     <= csr_pwdata[15:0];
            owvm_pkg::REG_TIMEOUT_TICKS:  timeout_ff <= csr_pwdata[15:0];
            owvm_pkg::REG_REVERSE:        reverse_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         owvm_pkg::REG_CHASSIS_RADIUS: csr_prdata = {16'd0, radius_ff};
         owvm_pkg::REG_WHEEL_SCALE:    csr_prdata = {16'd0, scale_ff};
         owvm_pkg::REG_NORTH_OFFSET:   csr_prdata = {16'd0, north_ff};
         owvm_pkg::REG_YAW_OFFSET:     csr_prdata = {16'd0, yaw_ff};
         owvm_pkg::REG_TIMEOUT_TICKS:  csr_prdata = {16'd0, timeout_ff};
         owvm_pkg::REG_REVERSE:        csr_prdata = {31'd0, reverse_ff};
         default:                      csr_prdata = 32'd0;
      endcase
   end

   // control
   owvm_pkg::state_type state_ff, state_in;
   logic        req_take, rsp_load, rsp_take, is_tick;
   logic        stale;
   logic [15:0] ticks_ff;

   owvm_pkg::cordic_type chain [0:NSTEP];

   assign req_take  = req.valid && req.ready;
   assign rsp_take  = rsp.valid && rsp.ready;
   assign is_tick   = (req.command == owvm_pkg::CMD_TICK);
   assign req.ready = (state_ff == owvm_pkg::S_IDLE);

   always_comb begin
      state_in = state_ff;
      rsp_load = 1'b0;
      unique case (state_ff)
         owvm_pkg::S_IDLE:
            if (req.valid) begin
               state_in = is_tick ? owvm_pkg::S_FINISH : owvm_pkg::S_ROTATE;
            end
         owvm_pkg::S_ROTATE:
            if (chain[NSTEP].valid) begin
               state_in = owvm_pkg::S_PRODUCT;
            end
         owvm_pkg::S_PRODUCT: state_in = owvm_pkg::S_SUM;
         owvm_pkg::S_SUM:     state_in = owvm_pkg::S_ROUND;
         owvm_pkg::S_ROUND:   state_in = owvm_pkg::S_SCALE;
         owvm_pkg::S_SCALE:   state_in = owvm_pkg::S_FINISH;
         owvm_pkg::S_FINISH:
            if (!rsp.valid || rsp.ready) begin
               rsp_load = 1'b1;
               state_in = owvm_pkg::S_IDLE;
            end
         default: state_in = owvm_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= owvm_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // staleness counter
   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff <= 16'hFFFF;
      end else if (req_take) begin
         if (!is_tick) begin
            ticks_ff <= 16'd0;
         end else if (ticks_ff != 16'hFFFF) begin
            ticks_ff <= ticks_ff + 16'd1;
         end
      end
   end

   assign stale = (ticks_ff > timeout_ff);

   // operand capture and steering angle
   logic [31:0]            ang_sum;
   logic [ANGLE_BITS-1:0]  ang;
   logic [31:0]            turn;
   logic signed [15:0]     vx_ff, vy_ff, w_ff;
   logic [1:0]             quad_ff;
   logic                   zero_ff;
   logic [29:0]            rest_ff;
   logic                   start_ff;

   always_comb begin
      unique case (req.command)
         owvm_pkg::CMD_TURRET:
            ang_sum = {16'd0, req.motor_angle} - {16'd0, yaw_ff};
         owvm_pkg::CMD_ABSOLUTE:
            ang_sum = {16'd0, req.gimbal_angle} + {16'd0, req.motor_angle}
                      - {16'd0, yaw_ff} - {16'd0, north_ff};
         default: ang_sum = 32'd0;
      endcase
      ang  = ang_sum[ANGLE_BITS-1:0];
      turn = 32'(ang) << ANGLE_SHIFT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 1'b0;
      end else begin
         start_ff <= req_take && !is_tick;
      end
      if (req_take) begin
         vx_ff   <= req.velocity_x;
         vy_ff   <= req.velocity_y;
         w_ff    <= req.turn_rate;
         quad_ff <= turn[31:30];
         rest_ff <= turn[29:0];
         zero_ff <= (turn[29:0] == 30'd0);
      end
   end

   // CORDIC cell row
   assign chain[0] = '{valid: start_ff, x: owvm_pkg::CORDIC_START, y: '0,
                       z: owvm_pkg::ANG_W'(rest_ff)};

   for (genvar i = 0; i < NSTEP; i++) begin : g_cell
      owvm_cordic_cell #(.STEP(i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_in  (chain[i]),
         .cell_out (chain[i+1])
      );
   end

   // quadrant fold
   logic signed [RW-1:0] fx, fy;
   logic signed [RW-1:0] cos_ff, cos_in, sin_ff, sin_in;

   always_comb begin
      fx = zero_ff ? owvm_pkg::UNIT_COS : chain[NSTEP].x;
      fy = zero_ff ? '0 : chain[NSTEP].y;
      case (quad_ff)
         2'd0:    begin cos_in = fx;  sin_in = fy;  end
         2'd1:    begin cos_in = -fy; sin_in = fx;  end
         2'd2:    begin cos_in = -fx; sin_in = -fy; end
         default: begin cos_in = fy;  sin_in = -fx; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (chain[NSTEP].valid) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   // products, sums, rounding and scaling; each stage registers the output of the one before
   logic signed [48:0] p_xs_ff, p_yc_ff, p_xc_ff, p_ys_ff;
   logic signed [32:0] p_rot_ff;
   logic signed [51:0] lin_in [4];
   logic signed [51:0] lin_ff [4];
   logic signed [31:0] v20_ff [4];
   logic signed [GW-1:0] goal_ff [4];
   logic signed [GW-1:0] goal_in [4];
   logic signed [49:0] sum_a, sum_b;
   logic signed [51:0] rot52;

   always_comb begin
      sum_a = 50'(p_xs_ff) + 50'(p_yc_ff);
      sum_b = 50'(p_xc_ff) - 50'(p_ys_ff);
      rot52 = 52'(p_rot_ff) <<< 14;
      lin_in[0] = 52'(sum_a) + rot52;
      lin_in[1] = rot52 - 52'(sum_b);
      lin_in[2] = rot52 - 52'(sum_a);
      lin_in[3] = 52'(sum_b) + rot52;
   end

   always_ff @(posedge clock) begin
      p_xs_ff  <= 49'(vx_ff) * 49'(sin_ff);
      p_yc_ff  <= 49'(vy_ff) * 49'(cos_ff);
      p_xc_ff  <= 49'(vx_ff) * 49'(cos_ff);
      p_ys_ff  <= 49'(vy_ff) * 49'(sin_ff);
      p_rot_ff <= 33'(w_ff) * $signed({17'd0, radius_ff});
   end

   for (genvar k = 0; k < 4; k++) begin : g_wheel
      logic signed [51:0] lin_rnd;
      logic signed [49:0] scaled;
      logic signed [30:0] g31;
      logic signed [31:0] g;

      always_comb begin
         lin_rnd = lin_ff[k] + 52'sd524288;
         scaled  = 50'(v20_ff[k]) * $signed({34'd0, scale_ff}) + 50'sd131072;
         g31     = scaled[48:18];
         g       = reverse_ff ? -32'(g31) : 32'(g31);
         if (g > 32'(owvm_pkg::GOAL_MAX)) begin
            goal_in[k] = owvm_pkg::GOAL_MAX;
         end else if (g < 32'(owvm_pkg::GOAL_MIN)) begin
            goal_in[k] = owvm_pkg::GOAL_MIN;
         end else begin
            goal_in[k] = g[GW-1:0];
         end
      end

      always_ff @(posedge clock) begin
         lin_ff[k] <= lin_in[k];
         v20_ff[k] <= lin_rnd[51:20];
         if (reset) begin
            goal_ff[k] <= '0;
         end else if (state_ff == owvm_pkg::S_SCALE) begin
            goal_ff[k] <= goal_in[k];
         end
      end
   end

   // result register
   logic                 rsp_valid_ff;
   logic signed [GW-1:0] out_ff [4];
   logic                 stale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         for (int k = 0; k < 4; k++) begin
            out_ff[k] <= stale ? '0 : goal_ff[k];
         end
         stale_ff <= stale;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.front_speed = out_ff[0];
   assign rsp.left_speed  = out_ff[1];
   assign rsp.back_speed  = out_ff[2];
   assign rsp.right_speed = out_ff[3];
   assign rsp.stale       = stale_ff;

`ifndef SYNTHESIS
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req.ready)
      else $error("input accepted while a transaction is in flight");

   a_motion_clears_ticks: assert property (@(posedge clock) disable iff (reset)
      (req_take && !is_tick) |=> (ticks_ff == 16'd0))
      else $error("motion command did not clear staleness counter");

   a_stale_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.stale) |-> (rsp.front_speed == '0 && rsp.left_speed == '0
         && rsp.back_speed == '0 && rsp.right_speed == '0))
      else $error("stale result carries nonzero goal");

   a_chain_in_rotate: assert property (@(posedge clock) disable iff (reset)
      chain[NSTEP].valid |-> (state_ff == owvm_pkg::S_ROTATE))
      else $error("CORDIC output outside rotate step");
`endif

endmodule

`default_nettype wire

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the omni wheel velocity mixer: directed table, then
// bursty random commands and ticks checked against a behavioral predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [15:0] vx;
      logic signed [15:0] vy;
      logic signed [15:0] w;
      logic [15:0]        gimbal;
      logic [15:0]        motor;
   } cmd_type;

   typedef struct packed {
      logic signed [23:0] front;
      logic signed [23:0] left;
      logic signed [23:0] back;
      logic signed [23:0] right;
      logic               stale;
   } goal_type;

   typedef struct {
      cmd_type  c;
      logic     typed;
      goal_type g;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   always #2 clock = ~clock;

   owvm_req_if req();
   owvm_rsp_if rsp();

   logic        csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [4:0]  csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   omni_wheel_velocity_mixer u_top (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // predictor state
   logic [15:0] radius_q, scale_q, north_q, yaw_q, timeout_q;
   logic        reverse_q;
   logic signed [23:0] goals_q [4];
   logic [15:0] ticks_q;

   goal_type goal_fifo [$];
   int       errors = 0;
   int       cycles = 0;
   int       hold_cycles = 0;
   row_type  rows [$];

   const longint ATAN [16] = '{536870912, 316933406, 167458907, 85004756,
      42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544,
      333772, 166886, 83443, 41722, 20861};

   task automatic report(string what, longint got, longint want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      errors++;
   endtask

   function automatic void cordic_sin_cos(input logic [15:0] ang,
                                          output longint c, output longint s);
      logic [31:0] t;
      logic [29:0] rest;
      longint x, y, z, dx, dy;
      t = {ang, 16'd0};
      rest = t[29:0];
      x = 64'sd1 << 30;
      y = 0;
      if (rest != 0) begin
         z = rest;
         x = 652032874;
         for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= ATAN[i];
            end else begin
               x += dx; y -= dy; z += ATAN[i];
            end
         end
      end
      case (t[31:30])
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   function automatic logic signed [23:0] wheel_goal_of(input longint lin);
      longint v20, g;
      v20 = (lin + (64'sd1 <<< 19)) >>> 20;
      g = (v20 * longint'(scale_q) + (64'sd1 <<< 17)) >>> 18;
      if (reverse_q) g = -g;
      if (g > 8388607) g = 8388607;
      if (g < -8388608) g = -8388608;
      return g[23:0];
   endfunction

   function automatic goal_type predict_goals(input cmd_type c);
      goal_type r;
      logic [15:0] ang;
      longint cs, sn, a, b, rot;
      logic st;
      if (c.command == owvm_pkg::CMD_TICK) begin
         if (ticks_q != 16'hFFFF) ticks_q++;
      end else begin
         ang = 0;
         if (c.command == owvm_pkg::CMD_TURRET) ang = c.motor - yaw_q;
         else if (c.command == owvm_pkg::CMD_ABSOLUTE)
            ang = c.gimbal + c.motor - yaw_q - north_q;
         cordic_sin_cos(ang, cs, sn);
         a = longint'(c.vx) * sn + longint'(c.vy) * cs;
         b = longint'(c.vx) * cs - longint'(c.vy) * sn;
         rot = longint'(c.w) * longint'(radius_q) * 16384;
         goals_q[0] = wheel_goal_of(a + rot);
         goals_q[1] = wheel_goal_of(-b + rot);
         goals_q[2] = wheel_goal_of(-a + rot);
         goals_q[3] = wheel_goal_of(b + rot);
         ticks_q = 0;
      end
      st = ticks_q > timeout_q;
      r.front = st ? 24'sd0 : goals_q[0];
      r.left  = st ? 24'sd0 : goals_q[1];
      r.back  = st ? 24'sd0 : goals_q[2];
      r.right = st ? 24'sd0 : goals_q[3];
      r.stale = st;
      return r;
   endfunction

   task automatic csr_write(input logic [2:0] idx, input logic [15:0] value);
      @(posedge clock);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= {16'd0, value};
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      case (idx)
         owvm_pkg::REG_CHASSIS_RADIUS: radius_q = value;
         owvm_pkg::REG_WHEEL_SCALE:    scale_q = value;
         owvm_pkg::REG_NORTH_OFFSET:   north_q = value;
         owvm_pkg::REG_YAW_OFFSET:     yaw_q = value;
         owvm_pkg::REG_TIMEOUT_TICKS:  timeout_q = value;
         owvm_pkg::REG_REVERSE:        reverse_q = value[0];
         default: ;
      endcase
   endtask

   task automatic drain();
      while (goal_fifo.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // drive one transaction; expectation is queued at acceptance
   task automatic send(input cmd_type c, input logic typed, input goal_type want);
      goal_type p;
      req.valid <= 1;
      req.command <= c.command; req.velocity_x <= c.vx; req.velocity_y <= c.vy;
      req.turn_rate <= c.w; req.gimbal_angle <= c.gimbal; req.motor_angle <= c.motor;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      p = predict_goals(c);
      if (typed && p != want) begin
         report("table row", longint'(p.front), longint'(want.front));
      end
      goal_fifo = {goal_fifo, p};
   endtask

   task automatic idle_req();
      req.valid <= 0;
   endtask

   function automatic cmd_type random_cmd();
      cmd_type c;
      int sel;
      c.command = 2'($urandom_range(0, 3));
      sel = $urandom_range(0, 9);
      c.vx = (sel == 0) ? 16'sh8000 : (sel == 1) ? 16'sh7FFF : 16'($urandom);
      c.vy = (sel == 2) ? 16'sh8000 : 16'($urandom);
      c.w = (sel == 3) ? 16'sh7FFF : (sel == 4) ? 16'sh8000 : 16'($urandom);
      c.gimbal = 16'($urandom);
      c.motor = (sel == 5) ? 16'(16'h4000 * $urandom_range(0, 3)) : 16'($urandom);
      return c;
   endfunction

   task automatic run_random(input int n);
      goal_type z;
      z = '0;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 3) == 0) begin
            idle_req();
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
         send(random_cmd(), 1'b0, z);
      end
      idle_req();
   endtask

   function automatic row_type mk(input logic [1:0] cm, input int vx, input int vy,
                                  input int w, input int g, input int m,
                                  input logic typed, input goal_type want);
      row_type r;
      r.c.command = cm; r.c.vx = 16'(vx); r.c.vy = 16'(vy); r.c.w = 16'(w);
      r.c.gimbal = 16'(g); r.c.motor = 16'(m); r.typed = typed; r.g = want;
      return r;
   endfunction

   // result side: random stall pattern, plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp.ready <= 0;
      end else begin
         rsp.ready <= (cycles % 200 < 60) ? 1'b1 : ($urandom_range(0, 2) != 0);
      end
   end

   always @(posedge clock) begin
      goal_type want;
      cycles <= cycles + 1;
      if (!reset && rsp.valid && rsp.ready) begin
         if (goal_fifo.size() == 0) begin
            report("unexpected result", 0, 0);
         end else begin
            want = goal_fifo.pop_front();
            if (rsp.front_speed !== want.front) report("front", rsp.front_speed, want.front);
            if (rsp.left_speed !== want.left) report("left", rsp.left_speed, want.left);
            if (rsp.back_speed !== want.back) report("back", rsp.back_speed, want.back);
            if (rsp.right_speed !== want.right) report("right", rsp.right_speed, want.right);
            if (rsp.stale !== want.stale) report("stale", rsp.stale, want.stale);
         end
      end
      if (cycles > 900000) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   initial begin
      goal_type z, stale0;
      row_type  r;
      z = '0;
      stale0 = '0; stale0.stale = 1;
      req.valid = 0; req.command = 0; req.velocity_x = 0; req.velocity_y = 0;
      req.turn_rate = 0; req.gimbal_angle = 0; req.motor_angle = 0;
      radius_q = 19661; scale_q = 4096; north_q = 0; yaw_q = 0;
      timeout_q = 100; reverse_q = 0;
      for (int k = 0; k < 4; k++) goals_q[k] = 0;
      ticks_q = 16'hFFFF;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      rows = {rows, mk(owvm_pkg::CMD_TICK, 0, 0, 0, 0, 0, 1, stale0)};
      rows = {rows, mk(owvm_pkg::CMD_CHASSIS, 0, 0, 0, 0, 0, 1, z)};
      rows = {rows, mk(owvm_pkg::CMD_CHASSIS, 32767, 0, 0, 0, 0, 0, z)};
      rows = {rows, mk(owvm_pkg::CMD_CHASSIS, -32768, -32768, -32768, 0, 0, 0, z)};
      rows = {rows, mk(owvm_pkg::CMD_CHASSIS, 32767, 32767, 32767, 0, 0, 0, z)};
      rows = {rows, mk(owvm_pkg::CMD_TURRET, 1024, 0, 0, 0, 16384, 0, z)};
      rows = {rows, mk(owvm_pkg::CMD_TURRET, 1024, -1024, 512, 0, 12345, 0, z)};
      rows = {rows, mk(owvm_pkg::CMD_TURRET, -1024, 2048, 0, 0, 65535, 0, z)};
      rows = {rows, mk(owvm_pkg::CMD_ABSOLUTE, 1024, 1024, 0, 65535, 65535, 0, z)};
      rows = {rows, mk(owvm_pkg::CMD_ABSOLUTE, 500, -700, -300, 32768, 8192, 0, z)};
      rows = {rows, mk(owvm_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, z)};
      foreach (rows[i]) send(rows[i].c, rows[i].typed, rows[i].g);
      idle_req();
      drain();

      // tiny timeout, reversed, extreme scale, radius and offsets
      csr_write(owvm_pkg::REG_TIMEOUT_TICKS, 16'd1);
      csr_write(owvm_pkg::REG_REVERSE, 16'd1);
      csr_write(owvm_pkg::REG_WHEEL_SCALE, 16'hFFFF);
      csr_write(owvm_pkg::REG_CHASSIS_RADIUS, 16'hFFFF);
      csr_write(owvm_pkg::REG_NORTH_OFFSET, 16'hFFFF);
      csr_write(owvm_pkg::REG_YAW_OFFSET, 16'h8000);
      r = mk(owvm_pkg::CMD_CHASSIS, 32767, 32767, 32767, 0, 0, 0, z);
      send(r.c, r.typed, r.g);
      r = mk(owvm_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, z);
      send(r.c, r.typed, r.g);
      r = mk(owvm_pkg::CMD_TICK, 0, 0, 0, 0, 0, 1, stale0);
      send(r.c, r.typed, r.g);
      idle_req();
      drain();
      run_random(300);
      drain();

      // long receiver hold-off while sender keeps offering
      hold_cycles = 400;
      csr_write(owvm_pkg::REG_TIMEOUT_TICKS, 16'd0);
      csr_write(owvm_pkg::REG_REVERSE, 16'd0);
      csr_write(owvm_pkg::REG_WHEEL_SCALE, 16'd0);
      csr_write(owvm_pkg::REG_CHASSIS_RADIUS, 16'd0);
      run_random(300);
      drain();

      csr_write(owvm_pkg::REG_TIMEOUT_TICKS, 16'hFFFF);
      csr_write(owvm_pkg::REG_WHEEL_SCALE, 16'd256);
      csr_write(owvm_pkg::REG_CHASSIS_RADIUS, 16'd19661);
      csr_write(owvm_pkg::REG_NORTH_OFFSET, 16'd0);
      csr_write(owvm_pkg::REG_YAW_OFFSET, 16'd0);
      run_random(500);
      drain();

      csr_write(owvm_pkg::REG_TIMEOUT_TICKS, 16'd3);
      csr_write(owvm_pkg::REG_WHEEL_SCALE, 16'($urandom));
      csr_write(owvm_pkg::REG_YAW_OFFSET, 16'($urandom));
      csr_write(owvm_pkg::REG_NORTH_OFFSET, 16'($urandom));
      csr_write(owvm_pkg::REG_REVERSE, 16'd1);
      run_random(500);
      drain();

      if (errors == 0) $display("tb OK");
      else $display("tb NOT OK");
      $finish;
   end

endmodule

### files.f
rtl/core/owvm_pkg.sv
rtl/core/owvm_chan_if.sv
rtl/core/owvm_cordic_cell.sv
rtl/core/omni_wheel_velocity_mixer.sv
sim/tb.sv
